FILE: rtl/core/dwcs_pkg.sv
// Package for the dual weighted cosine similarity block.
// Widths, shared types and constants; no dependencies.
package dwcs_pkg;

  localparam int IN_W     = 24;
  localparam int SUM_W    = 36;
  localparam int SQ_W     = 60;
  localparam int PROD_W   = 2 * IN_W;
  localparam int QR       = 24;
  localparam int DIV_N_W  = 60;
  localparam int DIV_D_W  = 60;
  localparam int DIV_Q_W  = QR + 1;
  localparam int DIV_SH_W = 7;
  localparam int DIV_C_W  = 8;
  localparam int ROOT_W   = 30;
  localparam int NSH_W    = 5;
  localparam int WHD_W    = DIV_Q_W + 1;
  localparam int W2_W     = 2 * WHD_W - QR;
  localparam int DEN_W    = W2_W + 1;
  localparam int FRAC_BITS_DEFAULT = 16;

  localparam logic [DIV_Q_W-1:0] ONE_QR = DIV_Q_W'(1) << QR;

  typedef struct packed {
    logic [SUM_W-1:0] ua;
    logic [SUM_W-1:0] ub;
    logic [SUM_W-1:0] ta;
    logic [SUM_W-1:0] tb;
    logic [SQ_W-1:0]  dot;
    logic [SQ_W-1:0]  sqa;
    logic [SQ_W-1:0]  sqb;
  } sums_t;

  typedef struct packed {
    logic                start;
    logic [DIV_N_W-1:0]  n;
    logic [DIV_D_W-1:0]  d;
    logic [DIV_SH_W-1:0] sh;
    logic [DIV_Q_W-1:0]  cap;
  } div_req_t;

endpackage

FILE: rtl/core/dual_weighted_cosine_similarity_top.sv
// Dual weighted cosine similarity. Element pairs stream in one beat per cycle
// and feed seven saturating running sums. The beat marked last closes the
// vectors: the input stalls while a sequencer runs the finish on one shared
// restoring divider (one quotient bit per cycle, 60 + shift steps per
// division, plus launch and collect) and one shared square-root unit (up to
// 29 normalize steps, one exit step, 30 root steps, plus launch and collect).
// The finish is four divisions and two roots; a zero vector skips it and
// reports status 1 with result 0. The result beat sits in an output register,
// so the next vector may start streaming while it waits to be taken. Depends
// on dwcs_pkg and submodules.
module dual_weighted_cosine_similarity_top
  import dwcs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [IN_W-1:0]      a_value,
  input  logic [IN_W-1:0]      b_value,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FRAC_BITS:0]   similarity,
  output logic                 status
);

  localparam logic [3:0] ST_ACC  = 4'd0;
  localparam logic [3:0] ST_CHK  = 4'd1;
  localparam logic [3:0] ST_HA   = 4'd2;
  localparam logic [3:0] ST_HB   = 4'd3;
  localparam logic [3:0] ST_RA   = 4'd4;
  localparam logic [3:0] ST_RB   = 4'd5;
  localparam logic [3:0] ST_MUL  = 4'd6;
  localparam logic [3:0] ST_CDIV = 4'd7;
  localparam logic [3:0] ST_DEN  = 4'd8;
  localparam logic [3:0] ST_SIM  = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  localparam logic [DIV_Q_W-1:0] SIM_ONE = DIV_Q_W'(1) << FRAC_BITS;

  logic [3:0] state;
  logic       launched;
  logic       take, clear;
  sums_t      sums;

  div_req_t           dreq;
  logic               ddone;
  logic [DIV_Q_W-1:0] dquot;

  logic               sq_start, sq_done;
  logic [SQ_W-1:0]    sq_v;
  logic [ROOT_W-1:0]  sq_root;
  logic [NSH_W-1:0]   sq_shifts;

  logic [DIV_Q_W-1:0] ha, hb, c, res;
  logic [ROOT_W-1:0]  ra, rb;
  logic [NSH_W-1:0]   s, t;
  logic [DIV_D_W-1:0] prod;
  logic [W2_W-1:0]    w2;
  logic [DEN_W-1:0]   den;
  logic               stat;

  logic [WHD_W-1:0]   whd;
  logic [2*WHD_W-1:0] whd_sq;
  logic [DEN_W-1:0]   den_sum;

  assign in_stall = (state != ST_ACC);
  assign take     = in_valid && !in_stall;
  assign clear    = (state == ST_DONE) && (!out_valid || !out_stall);

  dwcs_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .clear   (clear),
    .a_value (a_value),
    .b_value (b_value),
    .sums    (sums)
  );

  // operand select for the shared divider
  always_comb begin
    dreq.start = !launched &&
                 (state == ST_HA || state == ST_HB || state == ST_CDIV || state == ST_SIM);
    dreq.n     = DIV_N_W'(sums.ua);
    dreq.d     = DIV_D_W'(sums.ta);
    dreq.sh    = DIV_SH_W'(QR);
    dreq.cap   = ONE_QR;
    unique case (state)
      ST_HB: begin
        dreq.n = DIV_N_W'(sums.ub);
        dreq.d = DIV_D_W'(sums.tb);
      end
      ST_CDIV: begin
        dreq.n  = sums.dot;
        dreq.d  = prod;
        dreq.sh = DIV_SH_W'(s) + DIV_SH_W'(t) + DIV_SH_W'(QR);
      end
      ST_SIM: begin
        dreq.n   = DIV_N_W'(c);
        dreq.d   = DIV_D_W'(den);
        dreq.sh  = DIV_SH_W'(FRAC_BITS);
        dreq.cap = SIM_ONE;
      end
      default: begin
      end
    endcase
  end

  dwcs_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (ddone),
    .quot (dquot)
  );

  assign sq_start = !launched && (state == ST_RA || state == ST_RB);
  assign sq_v     = (state == ST_RB) ? sums.sqb : sums.sqa;

  dwcs_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (sq_start),
    .v      (sq_v),
    .done   (sq_done),
    .root   (sq_root),
    .shifts (sq_shifts)
  );

  always_comb begin
    whd     = WHD_W'(ha) + WHD_W'(hb);
    whd_sq  = (2*WHD_W)'(whd) * (2*WHD_W)'(whd);
    den_sum = DEN_W'(w2) + DEN_W'(c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      launched  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // drop a taken beat; the finish state reloads the register itself
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      if (dreq.start || sq_start) begin
        launched <= 1'b1;
      end
      unique case (state)
        ST_ACC: begin
          if (take && last) begin
            state <= ST_CHK;
          end
        end
        ST_CHK: begin
          res <= '0;
          if (sums.ta == '0 || sums.tb == '0 || sums.sqa == '0 || sums.sqb == '0) begin
            stat  <= 1'b1;
            state <= ST_DONE;
          end else begin
            stat  <= 1'b0;
            state <= ST_HA;
          end
        end
        ST_HA: begin
          if (ddone) begin
            ha       <= dquot;
            launched <= 1'b0;
            state    <= ST_HB;
          end
        end
        ST_HB: begin
          if (ddone) begin
            hb       <= dquot;
            launched <= 1'b0;
            state    <= ST_RA;
          end
        end
        ST_RA: begin
          if (sq_done) begin
            ra       <= sq_root;
            s        <= sq_shifts;
            launched <= 1'b0;
            state    <= ST_RB;
          end
        end
        ST_RB: begin
          if (sq_done) begin
            rb       <= sq_root;
            t        <= sq_shifts;
            launched <= 1'b0;
            state    <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= DIV_D_W'(ra) * DIV_D_W'(rb);
          w2    <= whd_sq[2*WHD_W-1:QR];
          state <= ST_CDIV;
        end
        ST_CDIV: begin
          if (ddone) begin
            c        <= dquot;
            launched <= 1'b0;
            state    <= ST_DEN;
          end
        end
        ST_DEN: begin
          den <= den_sum;
          // zero denominator: result stays zero, status ok
          state <= (den_sum == '0) ? ST_DONE : ST_SIM;
        end
        ST_SIM: begin
          if (ddone) begin
            res      <= dquot;
            launched <= 1'b0;
            state    <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free, then load the beat
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            similarity <= res[FRAC_BITS:0];
            status     <= stat;
            state      <= ST_ACC;
          end
        end
        default: begin
          state <= ST_ACC;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/dwcs_accum.sv
// Running sums of the element pairs, saturating.
// Depends on dwcs_pkg.
module dwcs_accum
  import dwcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic              clear,
  input  logic [IN_W-1:0]   a_value,
  input  logic [IN_W-1:0]   b_value,
  output sums_t             sums
);

  sums_t sums_next;
  logic  unmatched;
  logic [PROD_W-1:0] pab, paa, pbb;

  function automatic logic [SUM_W-1:0] sat36(logic [SUM_W-1:0] acc, logic [IN_W-1:0] x);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W+1)'(x);
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  function automatic logic [SQ_W-1:0] sat60(logic [SQ_W-1:0] acc, logic [PROD_W-1:0] x);
    logic [SQ_W:0] s;
    s = {1'b0, acc} + (SQ_W+1)'(x);
    return s[SQ_W] ? '1 : s[SQ_W-1:0];
  endfunction

  always_comb begin
    unmatched = (a_value == '0) || (b_value == '0);
    pab = PROD_W'(a_value) * PROD_W'(b_value);
    paa = PROD_W'(a_value) * PROD_W'(a_value);
    pbb = PROD_W'(b_value) * PROD_W'(b_value);
    sums_next     = sums;
    sums_next.ua  = unmatched ? sat36(sums.ua, a_value) : sums.ua;
    sums_next.ub  = unmatched ? sat36(sums.ub, b_value) : sums.ub;
    sums_next.ta  = sat36(sums.ta, a_value);
    sums_next.tb  = sat36(sums.tb, b_value);
    sums_next.dot = sat60(sums.dot, pab);
    sums_next.sqa = sat60(sums.sqa, paa);
    sums_next.sqb = sat60(sums.sqb, pbb);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sums <= '0;
    end else if (take) begin
      sums <= sums_next;
    end
  end

endmodule

FILE: rtl/core/dwcs_div.sv
// Shared restoring divider: floor(n * 2^sh / d), capped, one bit per cycle.
// Depends on dwcs_pkg.
module dwcs_div
  import dwcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  div_req_t           req,
  output logic               done,
  output logic [DIV_Q_W-1:0] quot
);

  logic               busy;
  logic [DIV_C_W-1:0] cnt;
  logic [DIV_N_W-1:0] nsh;
  logic [DIV_D_W:0]   rem;
  logic [DIV_D_W-1:0] d;
  logic [DIV_Q_W-1:0] q, cap;
  logic               sat;

  logic [DIV_D_W:0]   trial, rem_next;
  logic               ge;
  logic [DIV_Q_W:0]   qw;

  always_comb begin
    trial    = {rem[DIV_D_W-1:0], nsh[DIV_N_W-1]};
    ge       = trial >= {1'b0, d};
    rem_next = ge ? trial - {1'b0, d} : trial;
    qw       = {q, ge};
  end

  assign quot = sat ? cap : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (cnt == DIV_C_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_C_W'(DIV_N_W) + DIV_C_W'(req.sh);
        nsh  <= req.n;
        rem  <= '0;
        d    <= req.d;
        q    <= '0;
        cap  <= req.cap;
        sat  <= 1'b0;
      end else if (busy) begin
        nsh <= nsh << 1;
        rem <= rem_next;
        q   <= qw[DIV_Q_W-1:0];
        sat <= sat | (qw > {1'b0, cap});
        cnt <= cnt - 1'b1;
        if (cnt == DIV_C_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/core/dwcs_sqrt.sv
// Normalize a nonzero square sum by powers of four, then take its floor root.
// Depends on dwcs_pkg.
module dwcs_sqrt
  import dwcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   v,
  output logic              done,
  output logic [ROOT_W-1:0] root,
  output logic [NSH_W-1:0]  shifts
);

  logic            busy, norm;
  logic [SQ_W-1:0] rem, r, bitv;
  logic [SQ_W:0]   trial;
  logic            ge;

  always_comb begin
    trial = {1'b0, r} + {1'b0, bitv};
    ge    = {1'b0, rem} >= trial;
  end

  assign root = r[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && !norm && bitv[0];
      if (start) begin
        busy   <= 1'b1;
        norm   <= 1'b1;
        rem    <= v;
        shifts <= '0;
      end else if (busy && norm) begin
        // shift by two until one of the top two bits is set
        if (rem[SQ_W-1:SQ_W-2] == 2'b00) begin
          rem    <= rem << 2;
          shifts <= shifts + 1'b1;
        end else begin
          norm <= 1'b0;
          r    <= '0;
          bitv <= SQ_W'(1) << (SQ_W - 2);
        end
      end else if (busy) begin
        if (ge) begin
          rem <= rem - trial[SQ_W-1:0];
          r   <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/core/dwcs_checker.sv
// Port-level checks for the similarity block, bound to its top level.
// Depends on dual_weighted_cosine_similarity_top.
module dwcs_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               last,
  input logic               out_valid,
  input logic               out_stall,
  input logic [FRAC_BITS:0] similarity,
  input logic               status
);

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last |=> in_stall)
    else $error("input not stalled after last beat");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> similarity <= ONE)
    else $error("similarity above one");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> similarity == '0)
    else $error("degenerate result not zero");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(similarity) && $stable(status))
    else $error("stalled result beat changed");

endmodule

bind dual_weighted_cosine_similarity_top dwcs_checker #(.FRAC_BITS(FRAC_BITS)) u_dwcs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .last       (last),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .similarity (similarity),
  .status     (status)
);
